/* hw/rtl/dhcp_option_scanner_core_defines.svh */
// Assertion macros used by the scanner RTL.
`ifndef DHCP_OPTION_SCANNER_CORE_DEFINES_SVH
`define DHCP_OPTION_SCANNER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DOS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define DOS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/dos_pkg.sv */
package dos_pkg;

    localparam int BYTE_W = 8;
    localparam int COOKIE_IDX_W = 2;

    localparam logic [BYTE_W-1:0] OPT_PAD      = 8'd0;
    localparam logic [BYTE_W-1:0] OPT_END      = 8'd255;
    localparam logic [BYTE_W-1:0] OPT_MSG_TYPE = 8'd53;
    localparam logic [BYTE_W-1:0] OPT_RELAY    = 8'd82;
    localparam logic [BYTE_W-1:0] MSG_DISCOVER = 8'd1;
    localparam logic [BYTE_W-1:0] MSG_REQUEST  = 8'd3;

    localparam logic [COOKIE_IDX_W-1:0] COOKIE_IDX_LAST = 2'd3;

    typedef enum logic [2:0] {
        PH_COOKIE,
        PH_ID,
        PH_LEN,
        PH_BODY_FIRST,
        PH_BODY_REST,
        PH_DONE
    } t_phase;

    function automatic logic [BYTE_W-1:0] cookie_byte(input logic [COOKIE_IDX_W-1:0] idx);
        logic [BYTE_W-1:0] v;
        case (idx)
            2'd0:    v = 8'h63;
            2'd1:    v = 8'h82;
            2'd2:    v = 8'h53;
            default: v = 8'h63;
        endcase
        return v;
    endfunction

endpackage

/* hw/rtl/dhcp_option_scanner_core.sv */
// Channel   Handshake                 Payload
// input     i_in_valid / o_in_stall   i_data_byte, i_is_last
// output    o_out_valid / i_out_stall o_insert_relay_info, o_message_type,
//                                     o_relay_info_present, o_cookie_ok, o_truncated
//
// One byte per cycle unless a stalled result holds a last byte; each byte is
// captured in the input register, and the scan state and result register then
// update from it. A result is valid once its last byte leaves the input register.
// Reset is synchronous, active low, and clears the scan state and both valids.
// A stalled result blocks only a last byte; all other bytes keep flowing.
`include "dhcp_option_scanner_core_defines.svh"

module dhcp_option_scanner_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [dos_pkg::BYTE_W-1:0]  i_data_byte,
    input  logic                        i_is_last,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_insert_relay_info,
    output logic [dos_pkg::BYTE_W-1:0]  o_message_type,
    output logic                        o_relay_info_present,
    output logic                        o_cookie_ok,
    output logic                        o_truncated
);
    import dos_pkg::*;

    logic                    r_in_valid;
    logic [BYTE_W-1:0]       r_in_byte;
    logic                    r_in_last;

    t_phase                  r_phase;
    t_phase                  n_phase;
    logic [COOKIE_IDX_W-1:0] r_cookie_index;
    logic [COOKIE_IDX_W-1:0] n_cookie_index;
    logic                    r_cookie_match;
    logic                    n_cookie_match;
    logic [BYTE_W-1:0]       r_current_option;
    logic [BYTE_W-1:0]       n_current_option;
    logic [BYTE_W-1:0]       r_bytes_left;
    logic [BYTE_W-1:0]       n_bytes_left;
    logic [BYTE_W-1:0]       r_pending_type;
    logic [BYTE_W-1:0]       n_pending_type;
    logic [BYTE_W-1:0]       r_committed_type;
    logic [BYTE_W-1:0]       n_committed_type;
    logic                    r_seen_relay;
    logic                    n_seen_relay;
    logic                    r_cut_short;
    logic                    n_cut_short;

    logic                    r_out_valid;
    logic                    r_out_insert;
    logic [BYTE_W-1:0]       r_out_type;
    logic                    r_out_relay;
    logic                    r_out_cookie_ok;
    logic                    r_out_truncated;

    logic                    w_s1_go;
    logic                    w_in_take;
    logic                    w_cookie_hit;
    logic [BYTE_W-1:0]       w_left_dec;
    logic                    w_ok;
    logic                    w_insert;

    assign w_s1_go   = r_in_valid && (!r_in_last || !r_out_valid || !i_out_stall);
    assign w_in_take = !r_in_valid || w_s1_go;
    assign o_in_stall = !w_in_take;

    assign w_cookie_hit = r_cookie_match && (r_in_byte == cookie_byte(r_cookie_index));
    assign w_left_dec   = r_bytes_left - 8'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_is_last;
        end
    end

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_COOKIE: begin
                if (r_cookie_index == COOKIE_IDX_LAST) begin
                    n_phase = w_cookie_hit ? PH_ID : PH_DONE;
                end
            end
            PH_ID: begin
                if (r_in_byte == OPT_END) begin
                    n_phase = PH_DONE;
                end else if (r_in_byte != OPT_PAD) begin
                    n_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                n_phase = (r_in_byte == '0) ? PH_ID : PH_BODY_FIRST;
            end
            PH_BODY_FIRST, PH_BODY_REST: begin
                n_phase = (w_left_dec == '0) ? PH_ID : PH_BODY_REST;
            end
            PH_DONE: begin
                n_phase = PH_DONE;
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase
    end

    always_comb begin
        n_cookie_index   = r_cookie_index;
        n_cookie_match   = r_cookie_match;
        n_current_option = r_current_option;
        n_bytes_left     = r_bytes_left;
        n_pending_type   = r_pending_type;
        n_committed_type = r_committed_type;
        n_seen_relay     = r_seen_relay;
        n_cut_short      = r_cut_short;
        unique case (r_phase)
            PH_COOKIE: begin
                n_cookie_match = w_cookie_hit;
                n_cookie_index = r_cookie_index + 2'd1;
            end
            PH_ID: begin
                if (r_in_byte != OPT_END && r_in_byte != OPT_PAD) begin
                    n_current_option = r_in_byte;
                    if (r_in_last) begin
                        n_cut_short = 1'b1;
                    end
                end
            end
            PH_LEN: begin
                n_bytes_left = r_in_byte;
                if (r_in_byte == '0) begin
                    if (r_current_option == OPT_RELAY) begin
                        n_seen_relay = 1'b1;
                    end
                end else if (r_in_last) begin
                    n_cut_short = 1'b1;
                end
            end
            PH_BODY_FIRST, PH_BODY_REST: begin
                if (r_phase == PH_BODY_FIRST && r_current_option == OPT_MSG_TYPE) begin
                    n_pending_type = r_in_byte;
                end
                n_bytes_left = w_left_dec;
                if (w_left_dec == '0) begin
                    if (r_current_option == OPT_MSG_TYPE) begin
                        n_committed_type = n_pending_type;
                    end
                    if (r_current_option == OPT_RELAY) begin
                        n_seen_relay = 1'b1;
                    end
                end else if (r_in_last) begin
                    n_cut_short = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign w_ok     = (n_phase != PH_COOKIE) && n_cookie_match;
    assign w_insert = w_ok && !n_seen_relay &&
                      (n_committed_type == MSG_DISCOVER || n_committed_type == MSG_REQUEST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_s1_go && r_in_last)) begin
            r_phase          <= PH_COOKIE;
            r_cookie_index   <= '0;
            r_cookie_match   <= 1'b1;
            r_current_option <= '0;
            r_bytes_left     <= '0;
            r_pending_type   <= '0;
            r_committed_type <= '0;
            r_seen_relay     <= 1'b0;
            r_cut_short      <= 1'b0;
        end else if (w_s1_go) begin
            r_phase          <= n_phase;
            r_cookie_index   <= n_cookie_index;
            r_cookie_match   <= n_cookie_match;
            r_current_option <= n_current_option;
            r_bytes_left     <= n_bytes_left;
            r_pending_type   <= n_pending_type;
            r_committed_type <= n_committed_type;
            r_seen_relay     <= n_seen_relay;
            r_cut_short      <= n_cut_short;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_go && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_go && r_in_last) begin
            r_out_insert    <= w_insert;
            r_out_type      <= n_committed_type;
            r_out_relay     <= n_seen_relay;
            r_out_cookie_ok <= w_ok;
            r_out_truncated <= n_cut_short;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_insert_relay_info  = r_out_insert;
    assign o_message_type       = r_out_type;
    assign o_relay_info_present = r_out_relay;
    assign o_cookie_ok          = r_out_cookie_ok;
    assign o_truncated          = r_out_truncated;

    `DOS_ASSERT_IMPL(a_insert_needs_cookie, i_clk, i_rst_n,
        o_out_valid && o_insert_relay_info,
        o_cookie_ok && !o_relay_info_present &&
        (o_message_type == MSG_DISCOVER || o_message_type == MSG_REQUEST),
        "insert flagged without its conditions")
    `DOS_ASSERT_IMPL(a_bad_cookie_clean, i_clk, i_rst_n,
        o_out_valid && !o_cookie_ok,
        o_message_type == '0 && !o_relay_info_present && !o_truncated,
        "options reported without a valid cookie")
    `DOS_ASSERT_IMPL(a_cookie_phase_clean, i_clk, i_rst_n,
        r_phase == PH_COOKIE,
        r_committed_type == '0 && !r_seen_relay && !r_cut_short,
        "option state set during cookie phase")
    `DOS_ASSERT_NEXT(a_last_rearms, i_clk, i_rst_n,
        w_s1_go && r_in_last,
        r_out_valid && r_phase == PH_COOKIE && r_cookie_index == '0,
        "last byte did not rearm the scanner")

endmodule
